// ===== hdl/ccp_pkg.sv =====
`default_nettype none

package ccp_pkg;

	// Frame geometry.
	localparam int FRAME_LEN = 8;
	localparam int POS_W = $clog2(FRAME_LEN);

	// ASCII codes used by the parser.
	localparam logic [7:0] CH_SCAN  = 8'h73;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] UP_HEX_OFFSET = 8'h37;
	localparam logic [7:0] LO_HEX_OFFSET = 8'h57;

	// Result codes.
	typedef enum logic [2:0] {
		OUT_SET_COLOR = 3'd0,
		OUT_SCAN      = 3'd1,
		OUT_BAD_ADDR  = 3'd2,
		OUT_BAD_RED   = 3'd3,
		OUT_BAD_GREEN = 3'd4,
		OUT_BAD_BLUE  = 3'd5
	} outcome_t;

	// One complete command frame, character 0 in the lowest slot.
	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	// One decoded result.
	typedef struct packed {
		outcome_t   outcome;
		logic [7:0] target_address;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
	} result_t;

	// A hex digit with its validity.
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} nibble_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t    n;
		logic [7:0] diff;
		n = '0;
		diff = '0;
		if (is_digit(c)) begin
			diff = c - CH_ZERO;
			n.ok = 1'b1;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			diff = c - UP_HEX_OFFSET;
			n.ok = 1'b1;
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			diff = c - LO_HEX_OFFSET;
			n.ok = 1'b1;
		end
		n.value = diff[3:0];
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ccp_char_if.sv =====
`default_nettype none

interface ccp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/ccp_result_if.sv =====
`default_nettype none

interface ccp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] outcome;
	logic [7:0] target_address;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;

	modport source (
		output valid, output outcome, output target_address,
		output red_level, output green_level, output blue_level,
		input ready
	);
	modport sink (
		input valid, input outcome, input target_address,
		input red_level, input green_level, input blue_level,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/ccp_decode.sv =====
`default_nettype none

module ccp_decode
	import ccp_pkg::*;
(
	input  frame_t  frame,
	output result_t result
);

	logic [7:0] c0;
	logic [7:0] c1;
	logic [3:0] d0;
	logic [3:0] d1;
	logic [7:0] magnitude;
	logic       negative;
	logic [7:0] address;
	nibble_t    red_hi, red_lo, green_hi, green_lo, blue_hi, blue_lo;
	logic [7:0] tens;

	assign c0 = frame[0];
	assign c1 = frame[1];
	assign d0 = c0[3:0];
	assign d1 = c1[3:0];
	assign tens = {4'd0, d0} * 8'd10;

	// Decimal address from the first two characters: space, sign, digits.
	always_comb begin
		magnitude = '0;
		negative = 1'b0;
		if (is_space(c0)) begin
			if (is_digit(c1)) begin
				magnitude = {4'd0, d1};
			end
		end else if (is_sign(c0)) begin
			negative = (c0 == CH_MINUS);
			if (is_digit(c1)) begin
				magnitude = {4'd0, d1};
			end
		end else if (is_digit(c0)) begin
			if (is_digit(c1)) begin
				magnitude = tens + {4'd0, d1};
			end else begin
				magnitude = {4'd0, d0};
			end
		end
		address = negative ? (8'd0 - magnitude) : magnitude;
	end

	// Hex digits of the three color pairs.
	assign red_hi   = hex_nibble(frame[2]);
	assign red_lo   = hex_nibble(frame[3]);
	assign green_hi = hex_nibble(frame[4]);
	assign green_lo = hex_nibble(frame[5]);
	assign blue_hi  = hex_nibble(frame[6]);
	assign blue_lo  = hex_nibble(frame[7]);

	// The first failing check picks the outcome; fields stay zero on failure.
	always_comb begin
		result = '0;
		priority if (c0 == CH_SCAN) begin
			result.outcome = OUT_SCAN;
		end else if (address == 8'd0) begin
			result.outcome = OUT_BAD_ADDR;
		end else if (!(red_hi.ok && red_lo.ok)) begin
			result.outcome = OUT_BAD_RED;
		end else if (!(green_hi.ok && green_lo.ok)) begin
			result.outcome = OUT_BAD_GREEN;
		end else if (!(blue_hi.ok && blue_lo.ok)) begin
			result.outcome = OUT_BAD_BLUE;
		end else begin
			result.outcome        = OUT_SET_COLOR;
			result.target_address = address;
			result.red_level      = {red_hi.value, red_lo.value};
			result.green_level    = {green_hi.value, green_lo.value};
			result.blue_level     = {blue_hi.value, blue_lo.value};
		end
	end

endmodule

`default_nettype wire

// ===== hdl/color_command_parser_core.sv =====
// Color command parser. Characters arrive on char_stream one per request,
// one per cycle unless input is held off, and are gathered into frames of
// eight. The eighth character of a frame yields exactly one result on
// result_stream: a scan request when the frame starts with 's', otherwise a
// set-color command with a decimal address from characters 0-1 and hex red,
// green and blue pairs from characters 2-7, or the error code of the first
// field that fails. The sustained rate is one character per cycle while the
// output is not stalled, set by the single write port of the frame buffer.
// The frame register takes the completed frame at the edge that accepts its
// eighth character; the combinational decoder feeds the result register,
// which takes the result once it is empty or its result is being taken.
// Input is held off only while both the frame register and the result
// register are full and the output is stalled.
`default_nettype none

module color_command_parser_core
	import ccp_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	ccp_char_if.sink        char_stream,
	ccp_result_if.source    result_stream
);

	logic [POS_W-1:0] pos_q;
	frame_t           buf_q;
	frame_t           frame_s1;
	logic             valid_s1;
	result_t          decoded;
	result_t          result_q;
	logic             out_valid_q;
	logic             load_out;
	logic             char_take;
	logic             frame_done;
	frame_t           frame_next;

	// Handshake and pipeline advance.
	assign load_out   = valid_s1 && (!out_valid_q || result_stream.ready);
	assign char_stream.ready = !valid_s1 || load_out;
	assign char_take  = char_stream.valid && char_stream.ready;
	assign frame_done = char_take && (pos_q == POS_W'(FRAME_LEN - 1));

	// Complete frame with the incoming character in the last slot.
	always_comb begin
		frame_next = buf_q;
		frame_next[FRAME_LEN-1] = char_stream.char_in;
	end

	// Frame position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (char_take) begin
			pos_q <= frame_done ? '0 : pos_q + 1'b1;
		end
	end

	// Frame buffer, written one character per request.
	always_ff @(posedge clk) begin
		if (char_take) begin
			buf_q[pos_q] <= char_stream.char_in;
		end
	end

	// Frame register feeding the decoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_done) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			frame_s1 <= frame_next;
		end
	end

	ccp_decode u_decode (
		.frame  (frame_s1),
		.result (decoded)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= decoded;
		end
	end

	assign result_stream.valid          = out_valid_q;
	assign result_stream.outcome        = 3'(result_q.outcome);
	assign result_stream.target_address = result_q.target_address;
	assign result_stream.red_level      = result_q.red_level;
	assign result_stream.green_level    = result_q.green_level;
	assign result_stream.blue_level     = result_q.blue_level;

endmodule

`default_nettype wire

// ===== tb/tb_color_command_parser_core.sv =====
`default_nettype none

module tb_color_command_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ccp_pkg::*;

	localparam int FRAMES_PER_PHASE = 25;
	localparam int NUM_PHASES = 4;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam logic [4:0] NOT_HEX = 5'd16;

	// Holds the characters of the frame in progress, decodes each complete
	// frame and checks the decoded commands against what the block returns.
	class color_frame_scoreboard;
		logic [7:0] frame_buf [FRAME_LEN];
		int unsigned fill;
		result_t pending[$];
		int unsigned errors;
		int unsigned results_seen;

		function new();
			fill = 0;
			errors = 0;
			results_seen = 0;
		endfunction

		function logic is_blank(logic [7:0] c);
			return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function logic is_dec(logic [7:0] c);
			return (c >= CH_ZERO) && (c <= CH_NINE);
		endfunction

		// Nibble value of a hex character, or NOT_HEX when it is not one.
		function logic [4:0] hex_val(logic [7:0] c);
			if (is_dec(c))
				return 5'(c - CH_ZERO);
			if (c >= CH_UP_A && c <= CH_UP_F)
				return 5'(c - CH_UP_A + 8'd10);
			if (c >= CH_LO_A && c <= CH_LO_F)
				return 5'(c - CH_LO_A + 8'd10);
			return NOT_HEX;
		endfunction

		// Byte of a hex pair; bit 8 flags a bad pair.
		function logic [8:0] hex_byte(logic [7:0] hi, logic [7:0] lo);
			logic [4:0] h;
			logic [4:0] l;
			h = hex_val(hi);
			l = hex_val(lo);
			if (h == NOT_HEX || l == NOT_HEX)
				return 9'h100;
			return {1'b0, h[3:0], l[3:0]};
		endfunction

		// Decimal address from two characters: blanks, one sign, then digits.
		// Negative values wrap modulo 256.
		function logic [7:0] parse_addr(logic [7:0] c0, logic [7:0] c1);
			logic [7:0] ch [2];
			int pos;
			bit neg;
			int val;
			ch[0] = c0;
			ch[1] = c1;
			pos = 0;
			neg = 1'b0;
			val = 0;
			while (pos < 2 && is_blank(ch[pos]))
				pos++;
			if (pos < 2 && (ch[pos] == CH_PLUS || ch[pos] == CH_MINUS)) begin
				neg = (ch[pos] == CH_MINUS);
				pos++;
			end
			while (pos < 2 && is_dec(ch[pos])) begin
				val = val * 10 + int'(ch[pos] - CH_ZERO);
				pos++;
			end
			if (neg)
				val = -val;
			return val[7:0];
		endfunction

		function result_t decode_frame();
			result_t r;
			logic [7:0] addr;
			logic [8:0] red;
			logic [8:0] green;
			logic [8:0] blue;
			r = '0;
			r.outcome = OUT_SET_COLOR;
			if (frame_buf[0] == CH_SCAN) begin
				r.outcome = OUT_SCAN;
				return r;
			end
			addr = parse_addr(frame_buf[0], frame_buf[1]);
			red = hex_byte(frame_buf[2], frame_buf[3]);
			green = hex_byte(frame_buf[4], frame_buf[5]);
			blue = hex_byte(frame_buf[6], frame_buf[7]);
			if (addr == 8'd0) begin
				r.outcome = OUT_BAD_ADDR;
			end else if (red[8]) begin
				r.outcome = OUT_BAD_RED;
			end else if (green[8]) begin
				r.outcome = OUT_BAD_GREEN;
			end else if (blue[8]) begin
				r.outcome = OUT_BAD_BLUE;
			end else begin
				r.target_address = addr;
				r.red_level = red[7:0];
				r.green_level = green[7:0];
				r.blue_level = blue[7:0];
			end
			return r;
		endfunction

		// An accepted character; the eighth of a frame yields one command.
		function void note_char(logic [7:0] c);
			frame_buf[fill] = c;
			if (fill == FRAME_LEN - 1) begin
				pending.push_back(decode_frame());
				fill = 0;
			end else begin
				fill++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			logic bad;
			results_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result %0d arrived with no command pending: outcome %0d",
						results_seen, got.outcome);
				return;
			end
			want = pending.pop_front();
			bad = (got.outcome !== want.outcome)
				|| (got.target_address !== want.target_address)
				|| (got.red_level !== want.red_level)
				|| (got.green_level !== want.green_level)
				|| (got.blue_level !== want.blue_level);
			if (bad) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"result %0d mismatch: expected outcome %0d addr %0d rgb %h %h %h,",
						" got outcome %0d addr %0d rgb %h %h %h"}, results_seen,
						want.outcome, want.target_address, want.red_level,
						want.green_level, want.blue_level, got.outcome,
						got.target_address, got.red_level, got.green_level,
						got.blue_level);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int src_idle_pct;
	int snk_stall_pct;
	int unsigned cycle_count;
	color_frame_scoreboard sb;

	ccp_char_if char_if ();
	ccp_result_if res_if ();

	color_command_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_stream   (char_if),
		.result_stream (res_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** color_command_parser_core: FAILED **");
			$finish;
		end
	end

	// The result side stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// Record accepted requests first, then check any result taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_if.valid && char_if.ready)
				sb.note_char(char_if.char_in);
			if (res_if.valid && res_if.ready)
				sb.check_result('{outcome_t'(res_if.outcome), res_if.target_address,
					res_if.red_level, res_if.green_level, res_if.blue_level});
		end
	end

	function automatic logic [7:0] pick_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_addr_char();
		int r;
		case ($urandom_range(0, 9))
			0: begin
				r = $urandom_range(0, 5);
				return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
			end
			1: return CH_PLUS;
			2: return CH_MINUS;
			3: return 8'($urandom_range(0, 255));
			default: return pick_digit();
		endcase
	endfunction

	function automatic logic [7:0] pick_hex_char();
		case ($urandom_range(0, 2))
			0: return pick_digit();
			1: return 8'(CH_UP_A + $urandom_range(0, 5));
			default: return 8'(CH_LO_A + $urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [7:0] pick_bad_hex_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (sb.hex_val(c) != NOT_HEX);
		return c;
	endfunction

	// A random frame: well-formed commands with random content, some scan
	// requests, frames whose first broken field is chosen, and pure noise.
	function automatic frame_t random_frame();
		frame_t f;
		int kind;
		int bad_pair;
		int which;
		logic [7:0] a0;
		logic [7:0] a1;
		kind = $urandom_range(0, 99);
		for (int i = 0; i < FRAME_LEN; i++)
			f[i] = 8'($urandom_range(0, 255));
		if (kind < 10) begin
			f[0] = CH_SCAN;
			return f;
		end
		if (kind < 26)
			return f;
		do begin
			a0 = pick_addr_char();
			a1 = pick_addr_char();
		end while (a0 == CH_SCAN
			|| ((kind < 36) != (sb.parse_addr(a0, a1) == 8'd0)));
		f[0] = a0;
		f[1] = a1;
		if (kind < 36 || kind >= 62)
			bad_pair = 3;
		else if (kind < 46)
			bad_pair = 0;
		else if (kind < 54)
			bad_pair = 1;
		else
			bad_pair = 2;
		for (int p = 0; p < 3; p++) begin
			f[2 + 2 * p] = pick_hex_char();
			f[3 + 2 * p] = pick_hex_char();
			if (p == bad_pair) begin
				which = $urandom_range(0, 2);
				if (which != 1)
					f[2 + 2 * p] = pick_bad_hex_char();
				if (which != 0)
					f[3 + 2 * p] = pick_bad_hex_char();
			end else if (p > bad_pair && $urandom_range(0, 3) == 0) begin
				f[2 + 2 * p] = 8'($urandom_range(0, 255));
			end
		end
		return f;
	endfunction

	// Offer one character, idling first at the rate of the current phase.
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			char_if.valid <= 1'b0;
			@(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.char_in <= c;
		do
			@(posedge clk);
		while (!char_if.ready);
	endtask

	task automatic send_frame(input frame_t f);
		for (int i = 0; i < FRAME_LEN; i++)
			send_char(f[i]);
	endtask

	initial begin
		frame_t f;
		sb = new();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		char_if.valid = 1'b0;
		char_if.char_in = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
				default: begin src_idle_pct = 36; snk_stall_pct = 36; end
			endcase
			if (phase == 0) begin
				// Scan request followed by extreme byte values.
				f = {"G", "9", "0", 8'h7F, 8'h80, 8'hFF, 8'h00, CH_SCAN};
				send_frame(f);
				// Negative address wrapping to 255, mixed-case hex extremes.
				f = {"A", "a", "0", "0", "F", "f", "1", "-"};
				send_frame(f);
				// Leading tab before a single digit, then a bad red pair.
				f = {"f", "a", "F", "9", "0", "G", "7", CH_TAB};
				send_frame(f);
			end
			repeat (FRAMES_PER_PHASE) begin
				f = random_frame();
				send_frame(f);
			end
		end
		char_if.valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** color_command_parser_core: PASSED **");
		else
			$display("** color_command_parser_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/ccp_pkg.sv
hdl/ccp_char_if.sv
hdl/ccp_result_if.sv
hdl/ccp_decode.sv
hdl/color_command_parser_core.sv
tb/tb_color_command_parser_core.sv
